// ----- hdl/edd_pkg.sv -----
// edd_pkg: shared codes for the edit distance engine.
// Command ops and controller states; no dependencies.
`default_nettype none

package edd_pkg;

  // Command op codes carried on op_i
  typedef enum logic [1:0] {
    OP_REF = 2'd0,  // append reference character
    OP_QRY = 2'd1,  // consume query character
    OP_END = 2'd2   // end of pair: report and clear
  } op_e;

  // Controller states
  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_DRAIN = 1'b1
  } st_e;

endpackage

`default_nettype wire

// ----- hdl/edit_distance_engine_top.sv -----
// edit_distance_engine_top: Levenshtein distance engine, command port plus cell chain.
// Depends on edd_pkg (op codes, states) and edd_cell.
//
//  channel   ports                         handshake
//  --------  ----------------------------  -------------------------------
//  command   op_i[1:0], ch_i[7:0]          taken when start_i & !busy_o
//  result    distance_o[6:0], overflow_o   one-cycle word marked by valid_o
//
// Sequence: reference (op 0) and query (op 1) words may follow back to back;
// each query word runs down the chain of MAX_LEN cells as a wavefront, one
// cell per cycle. An end word (op 2) holds busy_o high while the last
// wavefront leaves the chain; the result word shows on the edge that drops
// busy_o, and the block is cleared in that cycle.
// Reset: rst_ni clears all control state; row entries return to their index.
// The receiver cannot stall: every result word is shown exactly once.
`default_nettype none

module edit_distance_engine_top #(
  parameter int MAX_LEN = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [1:0] op_i,
  input  logic [7:0] ch_i,
  output logic       valid_o,
  output logic [6:0] distance_o,
  output logic       overflow_o
);

  localparam int DW = $clog2(MAX_LEN + 1);  // row entries stay within 0..MAX_LEN
  localparam logic [DW-1:0] MAX_V = DW'(MAX_LEN);
  localparam logic [DW-1:0] ONE_V = DW'(1);

  edd_pkg::st_e state_q, state_d;
  logic [DW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] ref_len_q;
  logic [DW-1:0] qry_len_q;
  logic          ovf_q;
  logic [DW-1:0] res_q;
  logic          valid_q;
  logic [6:0]    dist_q;
  logic          ovf_out_q;

  logic accept, ref_we, inj, emit, ovf_set;
  logic [31:0] res_ext;
  logic [6:0]  dist_d;

  // wavefront taps; slot 0 is the injection point, slot MAX_LEN the exit
  logic          tok_vld [MAX_LEN+1];
  logic [7:0]    tok_ch  [MAX_LEN+1];
  logic [DW-1:0] tok_new [MAX_LEN+1];
  logic [DW-1:0] tok_old [MAX_LEN+1];
  logic [DW-1:0] tok_res [MAX_LEN+1];

  assign accept = start_i && !busy_o;

  // command decode
  always_comb begin
    ref_we  = 1'b0;
    inj     = 1'b0;
    ovf_set = 1'b0;
    if (accept) begin
      case (edd_pkg::op_e'(op_i))
        edd_pkg::OP_REF: begin
          // reference is frozen once the query has started
          if (qry_len_q == '0) begin
            if (ref_len_q == MAX_V) ovf_set = 1'b1;
            else                    ref_we  = 1'b1;
          end
        end
        edd_pkg::OP_QRY: begin
          if (qry_len_q == MAX_V) ovf_set = 1'b1;
          else                    inj     = 1'b1;
        end
        default: ;  // op 2 handled by the state machine, op 3 ignored
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      edd_pkg::ST_IDLE:  if (accept && (op_i == edd_pkg::OP_END)) state_d = edd_pkg::ST_DRAIN;
      edd_pkg::ST_DRAIN: if (cnt_q == '0) state_d = edd_pkg::ST_IDLE;
      default:           state_d = edd_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    busy_o = 1'b0;
    emit   = 1'b0;
    cnt_d  = cnt_q;
    case (state_q)
      edd_pkg::ST_IDLE: begin
        cnt_d = MAX_V;
      end
      edd_pkg::ST_DRAIN: begin
        busy_o = 1'b1;
        emit   = (cnt_q == '0);
        cnt_d  = cnt_q - ONE_V;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= edd_pkg::ST_IDLE;
      cnt_q     <= '0;
      ref_len_q <= '0;
      qry_len_q <= '0;
      ovf_q     <= 1'b0;
      res_q     <= '0;
      valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      valid_q <= emit;
      if (emit) begin
        ref_len_q <= '0;
        qry_len_q <= '0;
        ovf_q     <= 1'b0;
        res_q     <= '0;
      end else begin
        if (ovf_set) ovf_q <= 1'b1;
        if (ref_we) begin
          ref_len_q <= ref_len_q + ONE_V;
          res_q     <= ref_len_q + ONE_V;  // distance to an empty query
        end
        if (inj) qry_len_q <= qry_len_q + ONE_V;
        if (tok_vld[MAX_LEN]) res_q <= tok_res[MAX_LEN];
      end
    end
  end

  // saturate to the 7-bit result
  always_comb begin
    res_ext = 32'(res_q);
    dist_d  = (res_ext > 32'd127) ? 7'd127 : res_ext[6:0];
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      dist_q    <= dist_d;
      ovf_out_q <= ovf_q;
    end
  end

  assign valid_o    = valid_q;
  assign distance_o = dist_q;
  assign overflow_o = ovf_out_q;

  // injection: left neighbor of column 1 is column 0, which holds the query length
  assign tok_vld[0] = inj;
  assign tok_ch[0]  = ch_i;
  assign tok_new[0] = qry_len_q + ONE_V;
  assign tok_old[0] = qry_len_q;
  assign tok_res[0] = qry_len_q + ONE_V;

  for (genvar g = 1; g <= MAX_LEN; g++) begin : g_cell
    edd_cell #(
      .DW  (DW),
      .IDX (g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .clr_i     (emit),
      .ref_we_i  (ref_we),
      .ref_len_i (ref_len_q),
      .ref_ch_i  (ch_i),
      .in_vld_i  (tok_vld[g-1]),
      .in_ch_i   (tok_ch[g-1]),
      .in_new_i  (tok_new[g-1]),
      .in_old_i  (tok_old[g-1]),
      .in_res_i  (tok_res[g-1]),
      .out_vld_o (tok_vld[g]),
      .out_ch_o  (tok_ch[g]),
      .out_new_o (tok_new[g]),
      .out_old_o (tok_old[g]),
      .out_res_o (tok_res[g])
    );
  end

  // chain must be empty when the result is taken and the block cleared
  a_drained : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> !tok_vld[MAX_LEN])
    else $error("wavefront still in chain at result");

  // a result word follows only a drain
  a_valid_after_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(state_q) == edd_pkg::ST_DRAIN)
    else $error("result word without drain");

  // lengths never pass the row size
  a_len_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ref_len_q <= MAX_V) && (qry_len_q <= MAX_V))
    else $error("string length out of range");

  // no wavefront enters while draining
  a_no_inj_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !inj && !ref_we)
    else $error("command taken while busy");

endmodule

`default_nettype wire

// ----- hdl/edd_cell.sv -----
// edd_cell: one column of the Wagner-Fischer row as a systolic cell.
// Holds one reference character and one row entry; uses no package items.
`default_nettype none

module edd_cell #(
  parameter int DW  = 7,
  parameter int IDX = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          clr_i,
  // reference load
  input  logic          ref_we_i,
  input  logic [DW-1:0] ref_len_i,
  input  logic [7:0]    ref_ch_i,
  // wavefront from left neighbor
  input  logic          in_vld_i,
  input  logic [7:0]    in_ch_i,
  input  logic [DW-1:0] in_new_i,
  input  logic [DW-1:0] in_old_i,
  input  logic [DW-1:0] in_res_i,
  // wavefront to right neighbor
  output logic          out_vld_o,
  output logic [7:0]    out_ch_o,
  output logic [DW-1:0] out_new_o,
  output logic [DW-1:0] out_old_o,
  output logic [DW-1:0] out_res_o
);

  localparam logic [DW-1:0] IDX_V  = DW'(IDX);
  localparam logic [DW-1:0] SLOT_V = DW'(IDX - 1);

  logic [7:0]    char_q;
  logic          loaded_q;
  logic [DW-1:0] dp_q, dp_d;
  logic          vld_q;
  logic [7:0]    ch_q;
  logic [DW-1:0] old_q;
  logic [DW-1:0] res_q;

  logic [DW:0] left_sum, up_sum, diag_sum, m01;

  // new entry = min(left_new + 1, above + 1, diag + mismatch)
  always_comb begin
    left_sum = {1'b0, in_new_i} + {{DW{1'b0}}, 1'b1};
    up_sum   = {1'b0, dp_q} + {{DW{1'b0}}, 1'b1};
    diag_sum = {1'b0, in_old_i} + {{DW{1'b0}}, (char_q != in_ch_i)};
    m01      = (left_sum < up_sum) ? left_sum : up_sum;
    dp_d     = (m01 < diag_sum) ? m01[DW-1:0] : diag_sum[DW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= 1'b0;
      vld_q    <= 1'b0;
      dp_q     <= IDX_V;
    end else if (clr_i) begin
      loaded_q <= 1'b0;
      vld_q    <= 1'b0;
      dp_q     <= IDX_V;
    end else begin
      if (ref_we_i && (ref_len_i == SLOT_V)) begin
        loaded_q <= 1'b1;
      end
      vld_q <= in_vld_i;
      if (in_vld_i) begin
        dp_q <= dp_d;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (ref_we_i && (ref_len_i == SLOT_V)) begin
      char_q <= ref_ch_i;
    end
    if (in_vld_i) begin
      ch_q  <= in_ch_i;
      old_q <= dp_q;
      res_q <= loaded_q ? dp_d : in_res_i;  // last loaded column wins
    end
  end

  assign out_vld_o = vld_q;
  assign out_ch_o  = ch_q;
  assign out_new_o = dp_q;
  assign out_old_o = old_q;
  assign out_res_o = res_q;

endmodule

`default_nettype wire
